// ----- rtl/lobm_pkg.sv -----
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

  localparam int MAX_RESTING = 32;
  localparam int IDX_W = $clog2(MAX_RESTING);

  typedef enum logic [1:0] {
    OP_LIMIT  = 2'd0,
    OP_MARKET = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    RK_TRADE     = 3'd0,
    RK_RESTED    = 3'd1,
    RK_FILLED    = 3'd2,
    RK_MKT_DROP  = 3'd3,
    RK_CANCELLED = 3'd4,
    RK_NOT_FOUND = 3'd5,
    RK_FULL_DROP = 3'd6
  } result_kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] order_id;
    logic        is_sell;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [63:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] maker_oid;
    logic [31:0] taker_oid;
    logic [31:0] trade_price;
    logic [31:0] trade_qty;
    logic [63:0] trade_time;
    logic        taker_sell;
    logic        last;
  } out_word_t;

  // One stored entry: id, side, price, remaining qty, arrival number.
  localparam int ENTRY_W = 32 + 1 + 32 + 32 + 32;

  typedef struct packed {
    logic [31:0] id;
    logic        sell;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] arrival;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT,
    ST_STATUS
  } state_t;

endpackage

// ----- rtl/lobm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/limit_order_book_matcher.sv -----
// Top level of the price-time priority limit order book matcher.
//
//   channel | ports                      | word
//   input   | in_valid in_ready in_data  | lobm_pkg::in_word_t
//   output  | out_valid out_ready out_data | lobm_pkg::out_word_t
//
// Each search sweeps the entry RAM, one entry a cycle, then decides. A cancel takes
// one search before its status word; a limit or market order with f fills takes
// f+1 searches, one less if the fills use up the quantity; zero qty goes to status.
// Reset (rst_n low, synchronous) clears all valid bits and the arrival counter.
// One word at a time; a stalled output holds the block in its emit or status state,
// and the next input word is taken only once the status word has gone to the holding register.
module limit_order_book_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lobm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lobm_pkg::out_word_t out_data
);
  import lobm_pkg::*;

  localparam int CNT_W = IDX_W + 1;

  state_t state_r, state_nxt;
  in_word_t req_r, req_nxt;
  logic [31:0] qty_r, qty_nxt;
  logic [MAX_RESTING-1:0] valid_r, valid_nxt;
  logic [31:0] arr_r, arr_nxt;

  // sweep
  logic [CNT_W-1:0] rcnt_r, rcnt_nxt;   // read address issued
  logic             rd_v_r, rd_v_nxt;   // read data valid next cycle
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             best_v_r, best_v_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_r, best_nxt;
  logic             free_v_r, free_v_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  // RAM
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RESTING)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // candidate compare for the entry currently out of the RAM
  logic        cand;
  logic        better;
  logic [31:0] age_c, age_b;
  logic        is_cancel;
  logic        out_free;

  always_comb begin
    is_cancel = (req_r.opcode == OP_CANCEL);
    age_c = arr_r - rdata.arrival;
    age_b = arr_r - best_r.arrival;
    if (is_cancel) begin
      cand = valid_r[rd_idx_r] && (rdata.id == req_r.order_id);
      better = !best_v_r || (age_c > age_b);
    end else begin
      cand = valid_r[rd_idx_r] && (rdata.sell != req_r.is_sell);
      if (!best_v_r) begin
        better = 1'b1;
      end else if (rdata.price != best_r.price) begin
        better = req_r.is_sell ? (rdata.price > best_r.price)
                               : (rdata.price < best_r.price);
      end else begin
        better = age_c > age_b;
      end
    end
  end

  logic        crosses;
  logic [31:0] fill;

  always_comb begin
    crosses = (req_r.opcode != OP_LIMIT) ||
              (req_r.is_sell ? (best_r.price >= req_r.limit_price)
                             : (best_r.price <= req_r.limit_price));
    fill = (qty_r < best_r.qty) ? qty_r : best_r.qty;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    qty_nxt       = qty_r;
    valid_nxt     = valid_r;
    arr_nxt       = arr_r;
    rcnt_nxt      = rcnt_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rcnt_r[IDX_W-1:0];
    best_v_nxt    = best_v_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = best_idx_r;
    wdata         = best_r;
    raddr         = rcnt_r[IDX_W-1:0];

    out_free = !out_valid_r || out_ready;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    out_nxt.maker_oid   = out_r.maker_oid;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          qty_nxt = in_data.quantity;
          if (in_data.opcode == OP_NONE) begin
            state_nxt = ST_IDLE;
          end else if (in_data.opcode != OP_CANCEL && in_data.quantity == 32'd0) begin
            state_nxt = ST_STATUS;
          end else begin
            state_nxt  = ST_SCAN;
            rcnt_nxt   = '0;
            best_v_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // issue one read a cycle, fold the previous read into the best pick
        if (rcnt_r < CNT_W'(MAX_RESTING)) begin
          rd_v_nxt = 1'b1;
          rcnt_nxt = rcnt_r + CNT_W'(1);
        end
        if (rd_v_r && cand && better) begin
          best_v_nxt   = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_nxt     = rdata;
        end
        if (rd_v_r && (rd_idx_r == IDX_W'(MAX_RESTING - 1))) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (is_cancel) begin
          state_nxt = ST_STATUS;
        end else if (best_v_r && crosses) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_STATUS;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = RK_TRADE;
          out_nxt.maker_oid   = best_r.id;
          out_nxt.taker_oid   = req_r.order_id;
          out_nxt.trade_price = best_r.price;
          out_nxt.trade_qty   = fill;
          out_nxt.trade_time  = req_r.timestamp;
          out_nxt.taker_sell  = req_r.is_sell;
          out_nxt.last        = 1'b0;
          we          = 1'b1;
          wdata.qty   = best_r.qty - fill;
          qty_nxt     = qty_r - fill;
          if (best_r.qty == fill) begin
            valid_nxt[best_idx_r] = 1'b0;
          end
          if (qty_r == fill) begin
            state_nxt = ST_STATUS;
          end else begin
            state_nxt  = ST_SCAN;
            rcnt_nxt   = '0;
            best_v_nxt = 1'b0;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.maker_oid   = '0;
          out_nxt.taker_oid   = req_r.order_id;
          out_nxt.trade_time  = req_r.timestamp;
          out_nxt.taker_sell  = req_r.is_sell;
          out_nxt.last        = 1'b1;
          out_nxt.trade_price = req_r.limit_price;
          out_nxt.trade_qty   = qty_r;
          state_nxt           = ST_IDLE;
          free_v_nxt          = 1'b0;
          free_idx_nxt        = '0;
          for (int i = MAX_RESTING - 1; i >= 0; i--) begin
            if (!valid_r[i]) begin
              free_v_nxt   = 1'b1;
              free_idx_nxt = IDX_W'(i);
            end
          end
          if (is_cancel) begin
            out_nxt.trade_price = best_v_r ? best_r.price : 32'd0;
            out_nxt.trade_qty   = best_v_r ? best_r.qty : 32'd0;
            out_nxt.result_kind = best_v_r ? RK_CANCELLED : RK_NOT_FOUND;
            if (best_v_r) begin
              valid_nxt[best_idx_r] = 1'b0;
            end
          end else if (req_r.opcode == OP_MARKET) begin
            out_nxt.trade_price = '0;
            out_nxt.result_kind = (qty_r == 32'd0) ? RK_FILLED : RK_MKT_DROP;
          end else if (qty_r == 32'd0) begin
            out_nxt.result_kind = RK_FILLED;
          end else if (!free_v_nxt) begin
            out_nxt.result_kind = RK_FULL_DROP;
          end else begin
            out_nxt.result_kind   = RK_RESTED;
            we                    = 1'b1;
            waddr                 = free_idx_nxt;
            wdata.id              = req_r.order_id;
            wdata.sell            = req_r.is_sell;
            wdata.price           = req_r.limit_price;
            wdata.qty             = qty_r;
            wdata.arrival         = arr_r;
            valid_nxt[free_idx_nxt] = 1'b1;
            arr_nxt               = arr_r + 32'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      arr_r       <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      best_v_r    <= 1'b0;
      rcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      arr_r       <= arr_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= rd_v_nxt;
      best_v_r    <= best_v_nxt;
      rcnt_r      <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    qty_r      <= qty_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    free_v_r   <= free_v_nxt;
    free_idx_r <= free_idx_nxt;
    out_r      <= out_nxt;
  end

  // a trade never leaves with last set
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == RK_TRADE |-> !out_data.last)
    else $error("trade word flagged last");

  // accepting a word never moves straight to emit
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_EMIT)
    else $error("emit right after accept");

  // a trade always moves a nonzero quantity
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free |-> fill != 32'd0)
    else $error("zero fill");

  // the arrival counter only moves when an order rests
  a_arr: assert property (@(posedge clk) disable iff (!rst_n)
    arr_r != $past(arr_r) |-> out_data.result_kind == RK_RESTED)
    else $error("arrival counter moved without a rest");

endmodule

// ----- bench/tb_limit_order_book_matcher.sv -----
// Testbench for the limit order book matcher: scoreboard class, drivers and checks.
`timescale 1ns / 1ps

module tb_limit_order_book_matcher;
  import lobm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  // Book predictor and queue of expected result words.
  class book_scoreboard;
    bit          live [MAX_RESTING];
    bit [31:0]   oid [MAX_RESTING];
    bit          side [MAX_RESTING];
    bit [31:0]   px [MAX_RESTING];
    bit [31:0]   rem [MAX_RESTING];
    bit [31:0]   arr [MAX_RESTING];
    bit [31:0]   next_arrival;
    out_word_t   pending [$];
    int          errors;
    int          words_seen;
    int          trades_seen;
    int          fulls_seen;

    function new();
      for (int i = 0; i < MAX_RESTING; i++) live[i] = 0;
      next_arrival = 0;
      errors = 0;
      words_seen = 0;
      trades_seen = 0;
      fulls_seen = 0;
    endfunction

    function int resting_count();
      int c;
      c = 0;
      for (int i = 0; i < MAX_RESTING; i++) c += live[i];
      return c;
    endfunction

    function void push(result_kind_t k, bit [31:0] mk, in_word_t w, bit [31:0] p,
                       bit [31:0] q, bit lst);
      out_word_t r;
      r.result_kind = k;
      r.maker_oid   = mk;
      r.taker_oid   = w.order_id;
      r.trade_price = p;
      r.trade_qty   = q;
      r.trade_time  = w.timestamp;
      r.taker_sell  = w.is_sell;
      r.last        = lst;
      pending.insert(pending.size(), r);
    endfunction

    // Best opposite-side maker by price, then by age (wrapping arrival).
    function int best_opposite(bit sell);
      int b;
      b = -1;
      for (int i = 0; i < MAX_RESTING; i++) begin
        if (!live[i] || side[i] == sell) continue;
        if (b < 0) b = i;
        else if (px[i] != px[b]) begin
          if (sell ? (px[i] > px[b]) : (px[i] < px[b])) b = i;
        end else if (bit'(32'(next_arrival - arr[i]) > 32'(next_arrival - arr[b]))) b = i;
      end
      return b;
    endfunction

    // Note an accepted input word and queue what it must produce.
    function void note_input(in_word_t w);
      bit [31:0] q, f;
      int m, slot;
      q = w.quantity;
      if (w.opcode == OP_NONE) return;
      if (w.opcode == OP_CANCEL) begin
        m = -1;
        for (int i = 0; i < MAX_RESTING; i++)
          if (live[i] && oid[i] == w.order_id &&
              (m < 0 || 32'(next_arrival - arr[i]) > 32'(next_arrival - arr[m]))) m = i;
        if (m < 0) push(RK_NOT_FOUND, 0, w, 0, 0, 1'b1);
        else begin
          live[m] = 0;
          push(RK_CANCELLED, 0, w, px[m], rem[m], 1'b1);
        end
        return;
      end
      while (q > 0) begin
        m = best_opposite(w.is_sell);
        if (m < 0) break;
        if (w.opcode == OP_LIMIT &&
            !(w.is_sell ? (px[m] >= w.limit_price) : (px[m] <= w.limit_price))) break;
        f = (q < rem[m]) ? q : rem[m];
        push(RK_TRADE, oid[m], w, px[m], f, 1'b0);
        rem[m] -= f;
        q -= f;
        if (rem[m] == 0) live[m] = 0;
      end
      if (w.opcode == OP_MARKET) begin
        if (q == 0) push(RK_FILLED, 0, w, 0, q, 1'b1);
        else push(RK_MKT_DROP, 0, w, 0, q, 1'b1);
        return;
      end
      if (q == 0) begin
        push(RK_FILLED, 0, w, w.limit_price, 0, 1'b1);
        return;
      end
      slot = -1;
      for (int i = 0; i < MAX_RESTING; i++)
        if (!live[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) begin
        push(RK_FULL_DROP, 0, w, w.limit_price, q, 1'b1);
        return;
      end
      live[slot] = 1;
      oid[slot]  = w.order_id;
      side[slot] = w.is_sell;
      px[slot]   = w.limit_price;
      rem[slot]  = q;
      arr[slot]  = next_arrival;
      next_arrival++;
      push(RK_RESTED, 0, w, w.limit_price, q, 1'b1);
    endfunction

    task report(string what, out_word_t got, out_word_t want);
      errors++;
      $display("MISMATCH %s: got %p want %p", what, got, want);
    endtask

    // Compare one delivered word with the oldest expectation.
    task check_result(out_word_t got);
      out_word_t want;
      words_seen++;
      if (got.result_kind == RK_TRADE) trades_seen++;
      if (got.result_kind == RK_FULL_DROP) fulls_seen++;
      if (pending.size() == 0) begin
        report("unexpected word", got, got);
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.result_kind != want.result_kind) report("result_kind", got, want);
      if (got.maker_oid   != want.maker_oid)   report("maker_oid", got, want);
      if (got.taker_oid   != want.taker_oid)   report("taker_oid", got, want);
      if (got.trade_price != want.trade_price) report("trade_price", got, want);
      if (got.trade_qty   != want.trade_qty)   report("trade_qty", got, want);
      if (got.trade_time  != want.trade_time)  report("trade_time", got, want);
      if (got.taker_sell  != want.taker_sell)  report("taker_sell", got, want);
      if (got.last        != want.last)        report("last", got, want);
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  book_scoreboard book;
  int  cycle_count = 0;
  bit  quiet_phase;     // no idling on either side
  int  hold_offs_asked; // long receiver stalls requested so far
  int  items_sent;

  limit_order_book_matcher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 0;
  always #1 clk = ~clk;

  // Count cycles; end the run at the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Note accepted input words in the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) book.note_input(in_data);
  end

  // Check delivered result words.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_data);
  end

  // Receiver: random stalls, a long hold-off on request.
  initial begin
    int stall;
    int holds_done;
    holds_done = 0;
    out_ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_offs_asked != holds_done) begin
        out_ready <= 0;
        stall = $urandom_range(400, 600);
        repeat (stall) @(posedge clk);
        holds_done++;
      end
      out_ready <= quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 11);
      @(posedge clk);
    end
  end

  // Drive one word; hold it until accepted, idling first at random.
  task send_word(in_word_t w);
    while (!quiet_phase && $urandom_range(0, 99) < 11) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task idle_cycle();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function in_word_t make_word(opcode_t op, bit [31:0] id, bit sell, bit [31:0] p,
                               bit [31:0] q);
    in_word_t w;
    w.opcode      = op;
    w.order_id    = id;
    w.is_sell     = sell;
    w.limit_price = p;
    w.quantity    = q;
    w.timestamp   = {$urandom, $urandom};
    return w;
  endfunction

  // Drain: wait for every expected word, then some settling cycles.
  task wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (book.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Random order near a price band so books cross often.
  function in_word_t random_order(int band);
    int r;
    bit [31:0] p, q, id;
    bit s;
    r  = $urandom_range(0, 99);
    s  = 1'($urandom_range(0, 1));
    id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40);
    p  = 1000 + $urandom_range(0, band);
    q  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 50);
    if (r < 3) q = 0;
    if (r < 60) return make_word(OP_LIMIT, id, s, p, q);
    if (r < 75) return make_word(OP_MARKET, id, s, p, q);
    if (r < 97) return make_word(OP_CANCEL, id, s, p, q);
    return make_word(OP_NONE, id, s, p, q);
  endfunction

  initial begin
    in_word_t w;
    book = new();
    quiet_phase = 0;
    hold_offs_asked = 0;
    items_sent = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every opcode, zero quantity, cancels, duplicates.
    send_word(make_word(OP_CANCEL, 32'd7, 1'b0, 0, 0));               // empty book
    send_word(make_word(OP_MARKET, 32'd1, 1'b0, 0, 32'd10));          // nothing to cross
    send_word(make_word(OP_LIMIT, 32'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_LIMIT, 32'd3, 1'b1, 32'd500, 32'd5));
    send_word(make_word(OP_LIMIT, 32'd3, 1'b1, 32'd500, 32'd6));      // duplicate id
    send_word(make_word(OP_LIMIT, 32'd4, 1'b0, 32'd0, 32'd0));        // zero quantity
    send_word(make_word(OP_MARKET, 32'd5, 1'b0, 0, 32'd0));           // zero market
    send_word(make_word(OP_LIMIT, 32'd6, 1'b0, 32'd499, 32'd4));      // no cross, rest
    send_word(make_word(OP_LIMIT, 32'hFFFF_FFFF, 1'b0, 32'd500, 32'd3)); // partial
    send_word(make_word(OP_CANCEL, 32'd3, 1'b0, 0, 0));               // earliest dup
    send_word(make_word(OP_NONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_LIMIT, 32'd8, 1'b1, 32'd0, 32'd2));        // sell sweep bids
    send_word(make_word(OP_MARKET, 32'd9, 1'b0, 0, 32'hFFFF_FFFF));   // sweep the asks
    send_word(make_word(OP_MARKET, 32'd10, 1'b1, 0, 32'hFFFF_FFFF));
    send_word(make_word(OP_CANCEL, 32'hFFFF_FFFF, 1'b1, 0, 0));
    wait_drained();

    // Fill the store with non-crossing bids, overflow it, then sweep it.
    for (int i = 0; i < MAX_RESTING + 2; i++)
      send_word(make_word(OP_LIMIT, 32'(100 + i), 1'b0, 32'(10 + i % 3), 32'd1));
    send_word(make_word(OP_MARKET, 32'd200, 1'b1, 0, 32'd40));
    wait_drained();

    // Hold off the receiver while words keep coming, so the input stalls.
    hold_offs_asked++;
    for (int i = 0; i < 20; i++) send_word(random_order(20));
    wait_drained();

    // Random traffic; a stretch without any idling in the middle.
    for (int i = 0; i < 340; i++) begin
      quiet_phase = (i >= 150 && i < 230);
      send_word(random_order((i < 200) ? 20 : 300));
    end
    quiet_phase = 0;

    wait_drained();
    $display("covered %0d input words, %0d result words, %0d trades, %0d full drops",
             items_sent, book.words_seen, book.trades_seen, book.fulls_seen);
    $display("book ended with %0d resting orders", book.resting_count());
    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", book.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
